// ===== hdl/bgf7_pkg.sv =====
// Shared types, codes and GF(7) helper functions for the bitsliced GF(7) vector ALU.
`timescale 1ns / 1ps

package bgf7_pkg;

    // fixed plane width of every vector field
    localparam int VEC_W       = 64;
    // default number of active lanes
    localparam int LANES_DEF   = 64;
    // packed widths of the stream payloads
    localparam int IN_FIELDS_W = 3 + 6 * VEC_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 3 * VEC_W;
    localparam int KIND_W      = 2;

    // one GF(7) element, patterns 0..7
    typedef logic [2:0] t_gf7;

    // operation codes carried in tuser
    localparam logic [KIND_W-1:0] KIND_ADD       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCALE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_SCALE = 2'd2;
    // unused code, behaves as add
    localparam logic [KIND_W-1:0] KIND_RSVD      = 2'd3;

    // handshake state of the output register
    typedef struct packed {
        logic load;   // capture a new beat
        logic valid;  // beat held in the output register
    } t_out_ctl;

    // pattern 7 stands for 0
    function automatic t_gf7 gf7_canon(input t_gf7 v);
        gf7_canon = (v == 3'd7) ? 3'd0 : v;
    endfunction

    // sum of two canonical elements, reduced once
    function automatic t_gf7 gf7_add(input t_gf7 x, input t_gf7 y);
        logic [3:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= 4'd7) begin
            s = s - 4'd7;
        end
        gf7_add = s[2:0];
    endfunction

    // product of two canonical elements; 8 is 1 mod 7 so fold the high bits
    function automatic t_gf7 gf7_mul(input t_gf7 x, input t_gf7 y);
        logic [5:0] p;
        logic [3:0] f;
        p = {3'b000, x} * {3'b000, y};
        f = {1'b0, p[5:3]} + {1'b0, p[2:0]};
        if (f >= 4'd7) begin
            f = f - 4'd7;
        end
        gf7_mul = f[2:0];
    endfunction

endpackage

// ===== hdl/bitsliced_gf7_vector_alu.sv =====
// Top level of the bitsliced GF(7) vector ALU: lane array, merge and output handshake.
//
//  Channel  Dir  tdata (low bit up)                                  tuser
//  s        in   scalar[3], a_units, a_middle, a_sign, b_units,      kind[2]
//                b_middle, b_sign (64 each), zero pad to 392
//  m        out  r_units, r_middle, r_sign (64 each)                 -
//
// One beat per cycle sustained while the output is not stalled; each result
// appears in the cycle after its input beat, held in the single output register
// behind the lane logic. The input is ready whenever the output register is empty
// or being drained, so a stalled output holds its beat and blocks the input only while
// full. Reset clears the output valid flag; the payload register is not reset.
`timescale 1ns / 1ps

module bitsliced_gf7_vector_alu #(
    parameter int LANES = bgf7_pkg::LANES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // scalar, a_units, a_middle, a_sign, b_units, b_middle, b_sign, pad
    input  logic [bgf7_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // kind
    input  logic [bgf7_pkg::KIND_W-1:0]        i_s_tuser,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // r_units, r_middle, r_sign
    output logic [bgf7_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready
);

    localparam int VW = bgf7_pkg::VEC_W;
    localparam logic [VW-1:0] LANE_MASK =
        (LANES >= VW) ? {VW{1'b1}} : ((VW'(1) << LANES) - VW'(1));

    logic [VW-1:0] a_u, a_m, a_s, b_u, b_m, b_s;
    logic [2:0]    scalar;
    logic [VW-1:0] r_u, r_m, r_s;

    bgf7_pkg::t_gf7 [LANES-1:0] lane_r;
    bgf7_pkg::t_out_ctl         ctl;

    logic r_valid;
    logic n_valid;

    // unpack the input beat
    assign scalar = i_s_tdata[2:0];
    assign a_u    = i_s_tdata[3 +      VW-1 : 3];
    assign a_m    = i_s_tdata[3 + 2 * VW-1 : 3 +     VW];
    assign a_s    = i_s_tdata[3 + 3 * VW-1 : 3 + 2 * VW];
    assign b_u    = i_s_tdata[3 + 4 * VW-1 : 3 + 3 * VW];
    assign b_m    = i_s_tdata[3 + 5 * VW-1 : 3 + 4 * VW];
    assign b_s    = i_s_tdata[3 + 6 * VW-1 : 3 + 5 * VW];

    // lane array
    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            bgf7_lane u_lane (
                .i_kind   (i_s_tuser),
                .i_scalar (scalar),
                .i_a      ({a_s[g], a_m[g], a_u[g]}),
                .i_b      ({b_s[g], b_m[g], b_u[g]}),
                .o_r      (lane_r[g])
            );
        end
    endgenerate

    // output register handshake
    assign o_s_tready = !r_valid || i_m_tready;
    assign ctl.load   = i_s_tvalid && o_s_tready;
    assign ctl.valid  = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (ctl.load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // merge lanes into planes
    bgf7_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_lane_r (lane_r),
        .o_units  (r_u),
        .o_middle (r_m),
        .o_sign   (r_s)
    );

    assign o_m_tdata  = {r_s, r_m, r_u};
    assign o_m_tvalid = ctl.valid;

    // an accepted beat is always presented next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted beat not presented");

    // no result lane carries the non-canonical pattern
    a_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_u & r_m & r_s) == '0))
        else $error("result lane holds pattern seven");

    // lanes above the active count stay zero
    a_idle_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (((r_u | r_m | r_s) & ~LANE_MASK) == '0))
        else $error("inactive lane is not zero");

endmodule

// ===== hdl/bgf7_lane.sv =====
// One GF(7) lane: add, scale, or add then scale.
`timescale 1ns / 1ps

module bgf7_lane (
    input  logic [bgf7_pkg::KIND_W-1:0] i_kind,
    input  bgf7_pkg::t_gf7              i_scalar,
    input  bgf7_pkg::t_gf7              i_a,
    input  bgf7_pkg::t_gf7              i_b,
    output bgf7_pkg::t_gf7              o_r
);

    bgf7_pkg::t_gf7 x;
    bgf7_pkg::t_gf7 y;
    bgf7_pkg::t_gf7 k;
    bgf7_pkg::t_gf7 sum;

    // canonical operands, scalar 7 counts as 0
    assign x   = bgf7_pkg::gf7_canon(i_a);
    assign y   = bgf7_pkg::gf7_canon(i_b);
    assign k   = bgf7_pkg::gf7_canon(i_scalar);
    assign sum = bgf7_pkg::gf7_add(x, y);

    // operation select; the unused code falls back to add
    always_comb begin
        case (i_kind)
            bgf7_pkg::KIND_SCALE:     o_r = bgf7_pkg::gf7_mul(x, k);
            bgf7_pkg::KIND_ADD_SCALE: o_r = bgf7_pkg::gf7_mul(sum, k);
            default:                  o_r = sum;
        endcase
    end

endmodule

// ===== hdl/bgf7_merge.sv =====
// Gathers lane results back into bit planes and holds them in the output register.
`timescale 1ns / 1ps

module bgf7_merge #(
    parameter int LANES = bgf7_pkg::LANES_DEF
) (
    input  logic                         i_clk,
    input  bgf7_pkg::t_out_ctl           i_ctl,
    input  bgf7_pkg::t_gf7 [LANES-1:0]   i_lane_r,
    output logic [bgf7_pkg::VEC_W-1:0]   o_units,
    output logic [bgf7_pkg::VEC_W-1:0]   o_middle,
    output logic [bgf7_pkg::VEC_W-1:0]   o_sign
);

    logic [bgf7_pkg::VEC_W-1:0] n_units;
    logic [bgf7_pkg::VEC_W-1:0] n_middle;
    logic [bgf7_pkg::VEC_W-1:0] n_sign;
    logic [bgf7_pkg::VEC_W-1:0] r_units;
    logic [bgf7_pkg::VEC_W-1:0] r_middle;
    logic [bgf7_pkg::VEC_W-1:0] r_sign;

    // bit-plane transpose; unused lanes read as zero
    genvar g;
    generate
        for (g = 0; g < bgf7_pkg::VEC_W; g++) begin : g_plane
            if (g < LANES) begin : g_act
                assign n_units[g]  = i_lane_r[g][0];
                assign n_middle[g] = i_lane_r[g][1];
                assign n_sign[g]   = i_lane_r[g][2];
            end else begin : g_off
                assign n_units[g]  = 1'b0;
                assign n_middle[g] = 1'b0;
                assign n_sign[g]   = 1'b0;
            end
        end
    endgenerate

    // payload register, loaded on each accepted beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_units  <= n_units;
            r_middle <= n_middle;
            r_sign   <= n_sign;
        end
    end

    assign o_units  = r_units;
    assign o_middle = r_middle;
    assign o_sign   = r_sign;

endmodule
